FILE: rtl/fcgrd_pkg.sv
// ----------------------------------------------------------------------------
// FastCGI request deframer package
// Shared types, codes and sizing constants for the request deframer.
// ----------------------------------------------------------------------------
package fcgrd_pkg;

  localparam int MAX_PAIRS  = 256;
  localparam int PAIR_CNT_W = $clog2(MAX_PAIRS + 1);

  // Record header layout and field values
  localparam logic [3:0]  HDR_LEN        = 4'd8;
  localparam logic [7:0]  REC_VERSION    = 8'd1;
  localparam logic [3:0]  KIND_BEGIN     = 4'd1;
  localparam logic [3:0]  KIND_PARAMS    = 4'd4;
  localparam logic [3:0]  KIND_STDIN     = 4'd5;
  localparam logic [15:0] RESPONDER_ROLE = 16'd1;
  localparam logic [15:0] BEGIN_MIN_LEN  = 16'd8;
  localparam logic [2:0]  BIDX_MAX       = 3'd7;

  // Byte kinds reported with each result
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_NAME  = 2'd1;
  localparam logic [1:0] EV_VALUE = 2'd2;
  localparam logic [1:0] EV_STDIN = 2'd3;

  // Error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_VERSION     = 4'd1;
  localparam logic [3:0] ERR_TYPE        = 4'd2;
  localparam logic [3:0] ERR_NEED_BEGIN  = 4'd3;
  localparam logic [3:0] ERR_BAD_BEGIN   = 4'd4;
  localparam logic [3:0] ERR_NEED_PARAMS = 4'd5;
  localparam logic [3:0] ERR_NEED_EMPTY  = 4'd6;
  localparam logic [3:0] ERR_NEED_STDIN  = 4'd7;
  localparam logic [3:0] ERR_OVERRUN     = 4'd8;

  typedef enum logic [2:0] {
    PH_BEGIN  = 3'd0,
    PH_PARAMS = 3'd1,
    PH_EMPTY  = 3'd2,
    PH_STDIN  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    PS_NAME_LEN  = 4'd0,
    PS_NAME_B1   = 4'd1,
    PS_NAME_B2   = 4'd2,
    PS_NAME_B3   = 4'd3,
    PS_VALUE_LEN = 4'd4,
    PS_VALUE_B1  = 4'd5,
    PS_VALUE_B2  = 4'd6,
    PS_VALUE_B3  = 4'd7,
    PS_NAME      = 4'd8,
    PS_VALUE     = 4'd9
  } pair_step_t;

  typedef struct packed {
    logic clear;
    logic step;
  } pair_ctl_t;

  typedef struct packed {
    logic [1:0] ev;
    logic       pend;
    logic       busy;
    logic       below_max;
  } pair_stat_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  payload;
    logic        record_end;
    logic        pair_end;
    logic        body_done;
    logic [3:0]  error_code;
    logic [15:0] session_id;
  } result_t;

  typedef struct packed {
    logic [3:0] err;
    phase_t     phase;
  } core_stat_t;

endpackage

FILE: rtl/fcgrd_in_if.sv
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel carrying one stream byte per transfer.
// ----------------------------------------------------------------------------
interface fcgrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/fcgrd_out_if.sv
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying one classified byte per transfer.
// ----------------------------------------------------------------------------
interface fcgrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  payload;
  logic        record_end;
  logic        pair_end;
  logic        body_done;
  logic [3:0]  error_code;
  logic [15:0] session_id;

  modport source (output valid, output event_res, output payload, output record_end,
                  output pair_end, output body_done, output error_code,
                  output session_id, input ready);
  modport sink   (input valid, input event_res, input payload, input record_end,
                  input pair_end, input body_done, input error_code,
                  input session_id, output ready);
endinterface

FILE: rtl/fastcgi_request_deframer_unit.sv
// ----------------------------------------------------------------------------
// FastCGI request deframer
// Splits one responder connection's byte stream into classified bytes.
// ----------------------------------------------------------------------------
// The rx channel takes the connection stream, one byte per transfer. The tx
// channel returns exactly one result per byte: its kind (framing, param name,
// param value or stdin), the echoed byte, the record, pair and body end flags,
// the held error code and the request id taken from the begin record.
// A byte is held in the input register, where the header, session and
// pair logic work on it, and its result is then held in the output register.
// A result thus reaches tx through the input and then the output register, and one
// byte is taken every cycle for as long as the receiver keeps taking results;
// the limit is the single state update per byte in the session and pair
// counters. When the receiver stalls, the output register holds its result,
// the input register keeps its byte (or takes one if it was empty), and
// rx.ready stays low until the waiting result is taken.
// Reset returns the block to awaiting a begin record with no error and a
// request id of zero; both registers are emptied. Once an error is latched or
// the input has ended, later bytes still produce results, with kind framing.
// ----------------------------------------------------------------------------
module fastcgi_request_deframer_unit
  import fcgrd_pkg::*;
(
  input logic         clk,
  input logic         rst,
  fcgrd_in_if.sink    rx,
  fcgrd_out_if.source tx
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       o_valid;
  result_t    res;
  result_t    res_q;
  core_stat_t stat;
  logic       advance;
  logic       fire;

  assign advance  = !o_valid || tx.ready;
  assign fire     = s1_valid && advance;
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) s1_byte <= rx.data_byte;
  end

  fcgrd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (s1_byte),
    .res       (res),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_q <= res;
  end

  assign tx.valid      = o_valid;
  assign tx.event_res  = res_q.event_res;
  assign tx.payload    = res_q.payload;
  assign tx.record_end = res_q.record_end;
  assign tx.pair_end   = res_q.pair_end;
  assign tx.body_done  = res_q.body_done;
  assign tx.error_code = res_q.error_code;
  assign tx.session_id = res_q.session_id;

  // The first error is kept until reset.
  a_err_held: assert property (@(posedge clk) disable iff (rst)
    (stat.err != ERR_NONE) |=> (stat.err == $past(stat.err)))
    else $error("latched error code changed");

  // Bytes after an error or after the end of input carry no events or flags.
  a_quiet_after_stop: assert property (@(posedge clk) disable iff (rst)
    (fire && (stat.err != ERR_NONE || stat.phase == PH_DONE)) |=>
    (tx.event_res == EV_NONE && !tx.record_end && !tx.pair_end && !tx.body_done))
    else $error("result produced after error or end of input");

  // The end of input always coincides with the end of a record.
  a_done_ends_record: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.body_done) |-> tx.record_end)
    else $error("body_done without record_end");

  // Every processed byte yields a result in the output register.
  a_fire_fills_output: assert property (@(posedge clk) disable iff (rst)
    fire |=> tx.valid)
    else $error("processed byte produced no result");

endmodule

FILE: rtl/fcgrd_pair.sv
// ----------------------------------------------------------------------------
// Name-value pair decoder
// Tracks length fields, name and value bytes of params content.
// ----------------------------------------------------------------------------
module fcgrd_pair
  import fcgrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  pair_ctl_t  ctl,
  input  logic [7:0] data_byte,
  output pair_stat_t stat
);

  pair_step_t            step, step_next;
  logic [30:0]           name_left, name_next;
  logic [30:0]           value_left, value_next;
  logic [22:0]           accum, accum_next;
  logic [PAIR_CNT_W-1:0] count, count_next;
  logic                  pair_done;
  logic                  lens_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= PS_NAME_LEN;
      name_left  <= '0;
      value_left <= '0;
      accum      <= '0;
      count      <= '0;
    end else if (fire && ctl.clear) begin
      step       <= PS_NAME_LEN;
      name_left  <= '0;
      value_left <= '0;
      accum      <= '0;
      count      <= '0;
    end else if (fire && ctl.step) begin
      step       <= step_next;
      name_left  <= name_next;
      value_left <= value_next;
      accum      <= accum_next;
      count      <= count_next;
    end
  end

  always_comb begin
    step_next  = step;
    name_next  = name_left;
    value_next = value_left;
    accum_next = accum;
    count_next = count;
    pair_done  = 1'b0;
    lens_done  = 1'b0;
    stat.ev    = EV_NONE;

    unique case (step)
      PS_NAME_LEN: begin
        if (data_byte[7]) begin
          accum_next = {16'd0, data_byte[6:0]};
          step_next  = PS_NAME_B1;
        end else begin
          name_next = {23'd0, data_byte};
          step_next = PS_VALUE_LEN;
        end
      end
      PS_NAME_B1, PS_NAME_B2, PS_VALUE_B1, PS_VALUE_B2: begin
        accum_next = {accum[14:0], data_byte};
        step_next  = pair_step_t'(step + 4'd1);
      end
      PS_NAME_B3: begin
        name_next = {accum, data_byte};
        step_next = PS_VALUE_LEN;
      end
      PS_VALUE_LEN: begin
        if (data_byte[7]) begin
          accum_next = {16'd0, data_byte[6:0]};
          step_next  = PS_VALUE_B1;
        end else begin
          value_next = {23'd0, data_byte};
          lens_done  = 1'b1;
        end
      end
      PS_VALUE_B3: begin
        value_next = {accum, data_byte};
        lens_done  = 1'b1;
      end
      PS_NAME: begin
        stat.ev   = EV_NAME;
        name_next = name_left - 31'd1;
        if (name_next == '0) begin
          if (value_left != '0) step_next = PS_VALUE;
          else pair_done = 1'b1;
        end
      end
      default: begin
        stat.ev = EV_VALUE;
        if (value_left != '0) value_next = value_left - 31'd1;
        if (value_next == '0) pair_done = 1'b1;
      end
    endcase

    // Both lengths known: an empty name and value closes the pair at once.
    if (lens_done) begin
      if (name_left != '0) step_next = PS_NAME;
      else if (value_next != '0) step_next = PS_VALUE;
      else pair_done = 1'b1;
    end

    if (pair_done) begin
      count_next = count + PAIR_CNT_W'(1);
      step_next  = PS_NAME_LEN;
    end

    stat.pend      = pair_done;
    stat.below_max = (count < PAIR_CNT_W'(MAX_PAIRS));
    // Past the pair bound the step is idle and the byte is only skipped.
    stat.busy      = stat.below_max ? (step_next != PS_NAME_LEN) : (step != PS_NAME_LEN);
  end

endmodule

FILE: rtl/fcgrd_core.sv
// ----------------------------------------------------------------------------
// Deframer core
// Header parsing, session ordering, record counting and error latching.
// ----------------------------------------------------------------------------
module fcgrd_core
  import fcgrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  output result_t    res,
  output core_stat_t stat
);

  localparam logic [2:0] HB_VERSION = 3'd0;
  localparam logic [2:0] HB_TYPE    = 3'd1;
  localparam logic [2:0] HB_ID_HI   = 3'd2;
  localparam logic [2:0] HB_ID_LO   = 3'd3;
  localparam logic [2:0] HB_LEN_HI  = 3'd4;
  localparam logic [2:0] HB_LEN_LO  = 3'd5;
  localparam logic [2:0] HB_PAD     = 3'd6;
  localparam logic [2:0] HB_RSVD    = 3'd7;

  phase_t      phase, phase_next;
  logic [3:0]  hidx, hidx_next;
  logic [3:0]  kind, kind_next;
  logic [15:0] ident, ident_next;
  logic [15:0] content, content_next;
  logic [7:0]  pad, pad_next;
  logic [2:0]  bidx, bidx_next;
  logic [7:0]  role, role_next;
  logic [15:0] sess, sess_next;
  logic [3:0]  err, err_next;
  logic [3:0]  err_raise;
  logic        finish;
  pair_ctl_t   pctl;
  pair_stat_t  pstat;

  fcgrd_pair u_pair (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .ctl       (pctl),
    .data_byte (data_byte),
    .stat      (pstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_BEGIN;
      hidx    <= '0;
      kind    <= '0;
      ident   <= '0;
      content <= '0;
      pad     <= '0;
      bidx    <= '0;
      role    <= '0;
      sess    <= '0;
      err     <= ERR_NONE;
    end else if (fire) begin
      phase   <= phase_next;
      hidx    <= hidx_next;
      kind    <= kind_next;
      ident   <= ident_next;
      content <= content_next;
      pad     <= pad_next;
      bidx    <= bidx_next;
      role    <= role_next;
      sess    <= sess_next;
      err     <= err_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    hidx_next      = hidx;
    kind_next      = kind;
    ident_next     = ident;
    content_next   = content;
    pad_next       = pad;
    bidx_next      = bidx;
    role_next      = role;
    sess_next      = sess;
    err_next       = err;
    err_raise      = ERR_NONE;
    finish         = 1'b0;
    pctl.clear     = 1'b0;
    pctl.step      = 1'b0;
    res.event_res  = EV_NONE;
    res.payload    = '0;
    res.record_end = 1'b0;
    res.pair_end   = 1'b0;
    res.body_done  = 1'b0;

    if (err == ERR_NONE && phase != PH_DONE) begin
      if (hidx < HDR_LEN) begin
        unique case (hidx[2:0])
          HB_VERSION: if (data_byte != REC_VERSION) err_raise = ERR_VERSION;
          HB_TYPE: begin
            if (data_byte != {4'd0, KIND_BEGIN} && data_byte != {4'd0, KIND_PARAMS} &&
                data_byte != {4'd0, KIND_STDIN}) begin
              err_raise = ERR_TYPE;
            end else begin
              kind_next = data_byte[3:0];
              priority if (phase == PH_BEGIN && kind_next != KIND_BEGIN)
                err_raise = ERR_NEED_BEGIN;
              else if (phase == PH_PARAMS && kind_next != KIND_PARAMS)
                err_raise = ERR_NEED_PARAMS;
              else if (phase == PH_EMPTY && kind_next != KIND_PARAMS)
                err_raise = ERR_NEED_EMPTY;
              else if (phase == PH_STDIN && kind_next != KIND_STDIN)
                err_raise = ERR_NEED_STDIN;
              else
                err_raise = ERR_NONE;
            end
          end
          HB_ID_HI:  ident_next = {data_byte, 8'd0};
          HB_ID_LO:  ident_next = {ident[15:8], data_byte};
          HB_LEN_HI: content_next = {data_byte, 8'd0};
          HB_LEN_LO: begin
            content_next = {content[15:8], data_byte};
            if (phase == PH_EMPTY && content_next != '0) err_raise = ERR_NEED_EMPTY;
          end
          HB_PAD:    pad_next = data_byte;
          HB_RSVD: begin
            if (kind == KIND_BEGIN && (ident == '0 || content < BEGIN_MIN_LEN))
              err_raise = ERR_BAD_BEGIN;
          end
          default: err_raise = ERR_NONE;
        endcase
        if (err_raise == ERR_NONE) begin
          hidx_next = hidx + 4'd1;
          if (hidx_next == HDR_LEN) begin
            bidx_next  = '0;
            pctl.clear = 1'b1;
            if (content_next == '0 && pad_next == '0) finish = 1'b1;
          end
        end
      end else if (content != '0) begin
        if (kind == KIND_BEGIN) begin
          if (bidx == 3'd0) role_next = data_byte;
          else if (bidx == 3'd1 && {role, data_byte} != RESPONDER_ROLE)
            err_raise = ERR_BAD_BEGIN;
        end else if (kind == KIND_STDIN) begin
          res.event_res = EV_STDIN;
          res.payload   = data_byte;
        end else if (pstat.below_max) begin
          pctl.step     = 1'b1;
          res.event_res = pstat.ev;
          res.payload   = (pstat.ev != EV_NONE) ? data_byte : 8'd0;
          res.pair_end  = pstat.pend;
        end
        if (bidx < BIDX_MAX) bidx_next = bidx + 3'd1;
        content_next = content - 16'd1;
        // Params content that stops inside a pair is an overrun.
        if (err_raise == ERR_NONE && kind == KIND_PARAMS && content_next == '0 &&
            pstat.busy)
          err_raise = ERR_OVERRUN;
        if (err_raise == ERR_NONE && content_next == '0 && pad == '0) finish = 1'b1;
      end else begin
        if (pad != '0) pad_next = pad - 8'd1;
        if (pad_next == '0) finish = 1'b1;
      end
    end

    if (finish) begin
      res.record_end = 1'b1;
      hidx_next      = '0;
      unique case (phase)
        PH_BEGIN: begin
          sess_next  = ident_next;
          phase_next = PH_PARAMS;
        end
        PH_PARAMS: phase_next = PH_EMPTY;
        PH_EMPTY:  phase_next = PH_STDIN;
        PH_STDIN: begin
          // An empty stdin record ends the request input.
          if (bidx_next == '0) begin
            res.body_done = 1'b1;
            phase_next    = PH_DONE;
          end
        end
        default: phase_next = phase;
      endcase
    end

    if (err_raise != ERR_NONE) begin
      err_next       = err_raise;
      res.event_res  = EV_NONE;
      res.payload    = '0;
      res.record_end = 1'b0;
      res.pair_end   = 1'b0;
      res.body_done  = 1'b0;
    end

    res.error_code = err_next;
    res.session_id = sess_next;
    stat.err       = err;
    stat.phase     = phase;
  end

endmodule
